@@ design/kclc_pkg.sv @@
package kclc_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_AWAIT   = 3'd1,
        MODE_OPEN    = 3'd2,
        MODE_NEW     = 3'd3,
        MODE_CONFIRM = 3'd4
    } t_mode;

    typedef enum logic [3:0] {
        EV_NONE     = 4'd0,
        EV_DETECT   = 4'd1,
        EV_OPENED   = 4'd2,
        EV_WRONG    = 4'd3,
        EV_CLOSED   = 4'd4,
        EV_CHANGED  = 4'd5,
        EV_MISMATCH = 4'd6,
        EV_LOST     = 4'd7,
        EV_DIGIT    = 4'd8
    } t_event;

    typedef enum logic [1:0] {
        REG_THRESHOLD = 2'd0,
        REG_TIMEOUT   = 2'd1,
        REG_AUTOCLOSE = 2'd2,
        REG_INTERVAL  = 2'd3
    } t_reg_index;

    localparam logic [3:0]  KEY_LAST_DIGIT = 4'd9;
    localparam logic [3:0]  KEY_A          = 4'd10;
    localparam logic [3:0]  KEY_B          = 4'd11;
    localparam logic [3:0]  KEY_C          = 4'd12;
    localparam logic [3:0]  KEY_D          = 4'd13;
    localparam logic [15:0] NO_ECHO        = 16'hFFFF;

    localparam logic [15:0] THRESHOLD_RESET = 16'd500;
    localparam logic [31:0] TIMEOUT_RESET   = 32'd10000;
    localparam logic [31:0] AUTOCLOSE_RESET = 32'd30000;
    localparam logic [15:0] INTERVAL_RESET  = 16'd100;

    typedef struct packed {
        logic        cmd;
        logic [31:0] now_ms;
        logic [15:0] distance_mm;
        logic [3:0]  key_code;
    } t_item;

    typedef struct packed {
        logic [15:0] presence_threshold_mm;
        logic [31:0] presence_timeout_ms;
        logic [31:0] close_after_ms;
        logic [15:0] sample_interval_ms;
    } t_cfg;

    typedef struct packed {
        logic        door_is_open;
        t_mode       mode_now;
        t_event      event_code;
        logic        key_beep;
        logic [2:0]  digits_shown;
    } t_result;

endpackage

@@ design/kclc_if.sv @@
interface kclc_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] now_ms;
    logic [15:0] distance_mm;
    logic [3:0]  key_code;

    modport source (output valid, cmd, now_ms, distance_mm, key_code, input ready);
    modport sink   (input valid, cmd, now_ms, distance_mm, key_code, output ready);
endinterface

interface kclc_out_if;
    logic       valid;
    logic       ready;
    logic       door_is_open;
    logic [2:0] mode_now;
    logic [3:0] event_code;
    logic       key_beep;
    logic [2:0] digits_shown;

    modport source (output valid, door_is_open, mode_now, event_code, key_beep, digits_shown,
                    input ready);
    modport sink   (input valid, door_is_open, mode_now, event_code, key_beep, digits_shown,
                    output ready);
endinterface

interface kclc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ design/kclc_core.sv @@
module kclc_core #(
    parameter int CODE_DIGITS = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  kclc_pkg::t_item  i_item,
    input  kclc_pkg::t_cfg   i_cfg,
    output kclc_pkg::t_result o_result
);
    localparam int DW = 4 * CODE_DIGITS;
    localparam int CW = $clog2(CODE_DIGITS + 1);
    localparam int SW = (CW > 3) ? CW : 3;
    localparam logic [CW-1:0] FULL = CW'(CODE_DIGITS);

    logic [DW-1:0] reset_code;

    kclc_pkg::t_mode r_mode, n_mode;
    logic            r_door, n_door;
    logic            r_presence, n_presence;
    logic [DW-1:0]   r_stored, n_stored;
    logic [DW-1:0]   r_entry, n_entry;
    logic [CW-1:0]   r_entry_cnt, n_entry_cnt;
    logic [DW-1:0]   r_new, n_new;
    logic [CW-1:0]   r_new_cnt, n_new_cnt;
    logic [31:0]     r_last_ms, n_last_ms;
    logic [31:0]     r_pres_ms, n_pres_ms;
    logic [31:0]     r_abs_ms, n_abs_ms;
    logic            r_armed, n_armed;

    // first digit most significant, digit i is (i mod 4) + 1
    for (genvar g = 0; g < CODE_DIGITS; g++) begin : g_reset_code
        assign reset_code[4*(CODE_DIGITS-1-g) +: 4] = 4'((g % 4) + 1);
    end

    // item decode
    logic        is_key, is_digit, taken, near;
    logic        detect, lost, pres_after, armed_after, auto_close;
    logic [31:0] since_last, since_pres, since_abs, abs_after;
    logic        k_await_digit, k_await_d, k_await_c, await_match;
    logic        k_open_c, k_open_a, k_new_digit, k_new_b;
    logic        k_conf_digit, k_conf_b, conf_match;

    always_comb begin
        is_key     = i_item.cmd;
        is_digit   = i_item.key_code <= kclc_pkg::KEY_LAST_DIGIT;
        since_last = i_item.now_ms - r_last_ms;
        since_pres = i_item.now_ms - r_pres_ms;
        taken      = !is_key && (since_last >= {16'd0, i_cfg.sample_interval_ms});
        near       = (i_item.distance_mm != kclc_pkg::NO_ECHO) &&
                     (i_item.distance_mm <= i_cfg.presence_threshold_mm);
        detect     = taken && near && !r_presence;
        lost       = taken && !near && r_presence && (since_pres > i_cfg.presence_timeout_ms);
        pres_after  = detect ? 1'b1 : (lost ? 1'b0 : r_presence);
        armed_after = detect ? 1'b0 : (lost ? 1'b1 : r_armed);
        abs_after   = lost ? i_item.now_ms : r_abs_ms;
        since_abs   = i_item.now_ms - abs_after;
        auto_close  = taken && !pres_after && r_door && armed_after &&
                      (since_abs >= i_cfg.close_after_ms);

        await_match   = (r_entry_cnt == FULL) && (r_entry == r_stored);
        conf_match    = (r_entry_cnt == FULL) && (r_new_cnt == FULL) && (r_entry == r_new);
        k_await_digit = is_key && (r_mode == kclc_pkg::MODE_AWAIT) && is_digit &&
                        (r_entry_cnt < FULL);
        k_await_d     = is_key && (r_mode == kclc_pkg::MODE_AWAIT) &&
                        (i_item.key_code == kclc_pkg::KEY_D);
        k_await_c     = is_key && (r_mode == kclc_pkg::MODE_AWAIT) &&
                        (i_item.key_code == kclc_pkg::KEY_C);
        k_open_c      = is_key && (r_mode == kclc_pkg::MODE_OPEN) &&
                        (i_item.key_code == kclc_pkg::KEY_C);
        k_open_a      = is_key && (r_mode == kclc_pkg::MODE_OPEN) &&
                        (i_item.key_code == kclc_pkg::KEY_A);
        k_new_digit   = is_key && (r_mode == kclc_pkg::MODE_NEW) && is_digit &&
                        (r_new_cnt < FULL);
        k_new_b       = is_key && (r_mode == kclc_pkg::MODE_NEW) &&
                        (i_item.key_code == kclc_pkg::KEY_B) && (r_new_cnt == FULL);
        k_conf_digit  = is_key && (r_mode == kclc_pkg::MODE_CONFIRM) && is_digit &&
                        (r_entry_cnt < FULL);
        k_conf_b      = is_key && (r_mode == kclc_pkg::MODE_CONFIRM) &&
                        (i_item.key_code == kclc_pkg::KEY_B);
    end

    // next state
    always_comb begin
        n_mode      = r_mode;
        n_door      = r_door;
        n_presence  = pres_after;
        n_stored    = r_stored;
        n_entry     = r_entry;
        n_entry_cnt = r_entry_cnt;
        n_new       = r_new;
        n_new_cnt   = r_new_cnt;
        n_last_ms   = taken ? i_item.now_ms : r_last_ms;
        n_pres_ms   = detect ? i_item.now_ms : r_pres_ms;
        n_abs_ms    = abs_after;
        n_armed     = armed_after;

        if (detect) begin
            n_mode = r_door ? kclc_pkg::MODE_OPEN : kclc_pkg::MODE_AWAIT;
        end
        if (lost) begin
            n_entry     = '0;
            n_entry_cnt = '0;
            n_new       = '0;
            n_new_cnt   = '0;
            n_mode      = kclc_pkg::MODE_IDLE;
        end
        if (auto_close) begin
            n_door  = 1'b0;
            n_mode  = kclc_pkg::MODE_IDLE;
            n_armed = 1'b0;
        end

        unique case (r_mode)
            kclc_pkg::MODE_AWAIT: begin
                if (k_await_digit) begin
                    n_entry     = DW'({r_entry, i_item.key_code});
                    n_entry_cnt = r_entry_cnt + 1'b1;
                end else if (k_await_d || k_await_c) begin
                    n_entry     = '0;
                    n_entry_cnt = '0;
                    if (k_await_c) begin
                        n_door = 1'b0;
                        n_mode = r_presence ? kclc_pkg::MODE_AWAIT : kclc_pkg::MODE_IDLE;
                    end else if (await_match) begin
                        n_door = 1'b1;
                        n_mode = kclc_pkg::MODE_OPEN;
                    end
                end
            end
            kclc_pkg::MODE_OPEN: begin
                if (k_open_c) begin
                    n_door = 1'b0;
                    n_mode = r_presence ? kclc_pkg::MODE_AWAIT : kclc_pkg::MODE_IDLE;
                end else if (k_open_a) begin
                    n_new     = '0;
                    n_new_cnt = '0;
                    n_mode    = kclc_pkg::MODE_NEW;
                end
            end
            kclc_pkg::MODE_NEW: begin
                if (k_new_digit) begin
                    n_new     = DW'({r_new, i_item.key_code});
                    n_new_cnt = r_new_cnt + 1'b1;
                end else if (k_new_b) begin
                    n_entry     = '0;
                    n_entry_cnt = '0;
                    n_mode      = kclc_pkg::MODE_CONFIRM;
                end
            end
            kclc_pkg::MODE_CONFIRM: begin
                if (k_conf_digit) begin
                    n_entry     = DW'({r_entry, i_item.key_code});
                    n_entry_cnt = r_entry_cnt + 1'b1;
                end else if (k_conf_b) begin
                    if (conf_match) begin
                        n_stored = r_entry;
                    end
                    n_entry     = '0;
                    n_entry_cnt = '0;
                    n_new       = '0;
                    n_new_cnt   = '0;
                    n_mode      = kclc_pkg::MODE_OPEN;
                end
            end
            default: begin
            end
        endcase
    end

    // result
    logic [CW-1:0] shown_raw;
    logic [SW-1:0] shown_ext;

    always_comb begin
        shown_raw = (n_mode == kclc_pkg::MODE_NEW) ? n_new_cnt : n_entry_cnt;
        shown_ext = SW'(shown_raw);

        o_result.door_is_open = n_door;
        o_result.mode_now     = n_mode;
        o_result.key_beep     = is_key && (i_item.key_code <= kclc_pkg::KEY_D);
        o_result.digits_shown = (shown_ext > SW'(7)) ? 3'd7 : shown_ext[2:0];

        if (auto_close || k_await_c || k_open_c) begin
            o_result.event_code = kclc_pkg::EV_CLOSED;
        end else if (lost) begin
            o_result.event_code = kclc_pkg::EV_LOST;
        end else if (detect) begin
            o_result.event_code = kclc_pkg::EV_DETECT;
        end else if (k_await_d) begin
            o_result.event_code = await_match ? kclc_pkg::EV_OPENED : kclc_pkg::EV_WRONG;
        end else if (k_conf_b) begin
            o_result.event_code = conf_match ? kclc_pkg::EV_CHANGED : kclc_pkg::EV_MISMATCH;
        end else if (k_await_digit || k_new_digit || k_conf_digit) begin
            o_result.event_code = kclc_pkg::EV_DIGIT;
        end else begin
            o_result.event_code = kclc_pkg::EV_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= kclc_pkg::MODE_IDLE;
            r_door      <= 1'b0;
            r_presence  <= 1'b0;
            r_stored    <= reset_code;
            r_entry     <= '0;
            r_entry_cnt <= '0;
            r_new       <= '0;
            r_new_cnt   <= '0;
            r_last_ms   <= '0;
            r_pres_ms   <= '0;
            r_abs_ms    <= '0;
            r_armed     <= 1'b0;
        end else if (i_fire) begin
            r_mode      <= n_mode;
            r_door      <= n_door;
            r_presence  <= n_presence;
            r_stored    <= n_stored;
            r_entry     <= n_entry;
            r_entry_cnt <= n_entry_cnt;
            r_new       <= n_new;
            r_new_cnt   <= n_new_cnt;
            r_last_ms   <= n_last_ms;
            r_pres_ms   <= n_pres_ms;
            r_abs_ms    <= n_abs_ms;
            r_armed     <= n_armed;
        end
    end

endmodule

@@ design/keypad_code_lock_controller_unit.sv @@
// Channel  | Dir | Payload                                                | Handshake
// ---------+-----+--------------------------------------------------------+-------------
// i_in     | in  | cmd, now_ms, distance_mm, key_code                     | valid/ready
// o_out    | out | door_is_open, mode_now, event_code, key_beep,          | valid/ready
//          |     | digits_shown                                           |
// i_cfg    | in  | index (0 threshold, 1 timeout, 2 auto close, 3 interval), data | valid/ready
//
// One item per cycle sustained while o_out is not stalled; each item goes through the input register,
// then a single pass of compare/subtract logic against the lock state into the result register.
// Reset is synchronous: state, stored code and register defaults are restored.
// A stalled result holds the result register; the input register keeps taking items until
// both are full, then i_in.ready drops. Configuration writes are always ready.
module keypad_code_lock_controller_unit #(
    parameter int CODE_DIGITS = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    kclc_in_if.sink           i_in,
    kclc_out_if.source        o_out,
    kclc_cfg_if.sink          i_cfg
);
    kclc_pkg::t_cfg    r_cfg;
    logic              r_in_valid;
    kclc_pkg::t_item   r_in;
    logic              r_out_valid;
    kclc_pkg::t_result r_out;
    kclc_pkg::t_result core_result;
    logic              advance;

    assign advance     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.presence_threshold_mm <= kclc_pkg::THRESHOLD_RESET;
            r_cfg.presence_timeout_ms   <= kclc_pkg::TIMEOUT_RESET;
            r_cfg.close_after_ms        <= kclc_pkg::AUTOCLOSE_RESET;
            r_cfg.sample_interval_ms    <= kclc_pkg::INTERVAL_RESET;
        end else if (i_cfg.valid) begin
            unique case (kclc_pkg::t_reg_index'(i_cfg.index))
                kclc_pkg::REG_THRESHOLD: r_cfg.presence_threshold_mm <= i_cfg.data[15:0];
                kclc_pkg::REG_TIMEOUT:   r_cfg.presence_timeout_ms   <= i_cfg.data;
                kclc_pkg::REG_AUTOCLOSE: r_cfg.close_after_ms        <= i_cfg.data;
                kclc_pkg::REG_INTERVAL:  r_cfg.sample_interval_ms    <= i_cfg.data[15:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in.cmd         <= i_in.cmd;
            r_in.now_ms      <= i_in.now_ms;
            r_in.distance_mm <= i_in.distance_mm;
            r_in.key_code    <= i_in.key_code;
        end
    end

    kclc_core #(
        .CODE_DIGITS (CODE_DIGITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_result (core_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.door_is_open = r_out.door_is_open;
    assign o_out.mode_now     = r_out.mode_now;
    assign o_out.event_code   = r_out.event_code;
    assign o_out.key_beep     = r_out.key_beep;
    assign o_out.digits_shown = r_out.digits_shown;

    a_await_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.mode_now == kclc_pkg::MODE_AWAIT) |-> !r_out.door_is_open)
        else $error("await mode with door open");

    a_change_needs_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && ((r_out.mode_now == kclc_pkg::MODE_NEW) ||
                        (r_out.mode_now == kclc_pkg::MODE_CONFIRM)) |-> r_out.door_is_open)
        else $error("code change with door locked");

    a_shown_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (32'(r_out.digits_shown) <= CODE_DIGITS))
        else $error("digit count beyond code length");

    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("processed item lost before result register");

endmodule

@@ dv/tb_keypad_code_lock_controller_unit.sv @@
module tb_keypad_code_lock_controller_unit;

    localparam int PIN_LEN     = 4;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 270;

    typedef struct {
        kclc_pkg::t_item   item;
        kclc_pkg::t_result want;
    } t_planned;

    logic i_clk;
    logic i_rst_n;

    kclc_in_if  in_ch ();
    kclc_out_if out_ch ();
    kclc_cfg_if cfg_ch ();

    keypad_code_lock_controller_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // lock state as the block should hold it
    logic [15:0] cfg_threshold = kclc_pkg::THRESHOLD_RESET;
    logic [31:0] cfg_timeout   = kclc_pkg::TIMEOUT_RESET;
    logic [31:0] cfg_autoclose = kclc_pkg::AUTOCLOSE_RESET;
    logic [15:0] cfg_interval  = kclc_pkg::INTERVAL_RESET;

    kclc_pkg::t_mode lock_mode = kclc_pkg::MODE_IDLE;
    logic        door_unlocked = 1'b0;
    logic        someone_here  = 1'b0;
    logic [15:0] saved_code    = 16'h1234;
    logic [15:0] entry_digits  = '0;
    logic [2:0]  entry_cnt     = '0;
    logic [15:0] fresh_digits  = '0;
    logic [2:0]  fresh_cnt     = '0;
    logic [31:0] last_sample_t = '0;
    logic [31:0] presence_t    = '0;
    logic [31:0] absence_t     = '0;
    logic        absence_live  = 1'b0;

    t_planned          queued_items[$];
    kclc_pkg::t_result awaited_results[$];
    kclc_pkg::t_result driven_want;
    logic [31:0] now_t = '0;
    int          planned_total = 0;
    int          error_count = 0;
    int          results_seen = 0;
    int          cycles = 0;
    int          burst_left = 0;
    int          gap_left = 0;

    function automatic void push_digit(inout logic [15:0] digits, inout logic [2:0] cnt,
                                       input logic [3:0] d, inout kclc_pkg::t_event ev);
        if (cnt < PIN_LEN) begin
            digits = {digits[11:0], d};
            cnt    = cnt + 3'd1;
            ev     = kclc_pkg::EV_DIGIT;
        end
    endfunction

    function automatic void shut_door(inout kclc_pkg::t_event ev);
        door_unlocked = 1'b0;
        if (someone_here) lock_mode = kclc_pkg::MODE_AWAIT;
        else lock_mode = kclc_pkg::MODE_IDLE;
        ev = kclc_pkg::EV_CLOSED;
    endfunction

    function automatic void take_sample(input logic [31:0] now, input logic [15:0] mm,
                                        inout kclc_pkg::t_event ev);
        logic [31:0] since_last;
        logic [31:0] since_seen;
        logic [31:0] since_gone;
        since_last = now - last_sample_t;
        if (since_last < {16'h0, cfg_interval}) return;
        last_sample_t = now;
        since_seen = now - presence_t;
        if (mm != kclc_pkg::NO_ECHO && mm <= cfg_threshold) begin
            if (!someone_here) begin
                someone_here = 1'b1;
                presence_t   = now;
                absence_live = 1'b0;
                if (door_unlocked) lock_mode = kclc_pkg::MODE_OPEN;
                else lock_mode = kclc_pkg::MODE_AWAIT;
                ev = kclc_pkg::EV_DETECT;
            end
        end else if (someone_here && since_seen > cfg_timeout) begin
            someone_here = 1'b0;
            entry_digits = '0;
            entry_cnt    = '0;
            fresh_digits = '0;
            fresh_cnt    = '0;
            absence_t    = now;
            absence_live = 1'b1;
            lock_mode    = kclc_pkg::MODE_IDLE;
            ev           = kclc_pkg::EV_LOST;
        end
        since_gone = now - absence_t;
        // auto close overrides a presence-lost event on the same sample
        if (!someone_here && door_unlocked && absence_live && since_gone >= cfg_autoclose) begin
            shut_door(ev);
            absence_live = 1'b0;
        end
    endfunction

    function automatic void press_key(input logic [3:0] k, inout kclc_pkg::t_event ev);
        logic is_digit;
        is_digit = (k <= kclc_pkg::KEY_LAST_DIGIT);
        case (lock_mode)
            kclc_pkg::MODE_AWAIT: begin
                if (is_digit) begin
                    push_digit(entry_digits, entry_cnt, k, ev);
                end else if (k == kclc_pkg::KEY_D) begin
                    if (entry_cnt == PIN_LEN && entry_digits == saved_code) begin
                        door_unlocked = 1'b1;
                        lock_mode     = kclc_pkg::MODE_OPEN;
                        ev            = kclc_pkg::EV_OPENED;
                    end else begin
                        ev = kclc_pkg::EV_WRONG;
                    end
                    entry_digits = '0;
                    entry_cnt    = '0;
                end else if (k == kclc_pkg::KEY_C) begin
                    shut_door(ev);
                    entry_digits = '0;
                    entry_cnt    = '0;
                end
            end
            kclc_pkg::MODE_OPEN: begin
                if (k == kclc_pkg::KEY_C) begin
                    shut_door(ev);
                end else if (k == kclc_pkg::KEY_A) begin
                    fresh_digits = '0;
                    fresh_cnt    = '0;
                    lock_mode    = kclc_pkg::MODE_NEW;
                end
            end
            kclc_pkg::MODE_NEW: begin
                if (is_digit) begin
                    push_digit(fresh_digits, fresh_cnt, k, ev);
                end else if (k == kclc_pkg::KEY_B && fresh_cnt == PIN_LEN) begin
                    entry_digits = '0;
                    entry_cnt    = '0;
                    lock_mode    = kclc_pkg::MODE_CONFIRM;
                end
            end
            kclc_pkg::MODE_CONFIRM: begin
                if (is_digit) begin
                    push_digit(entry_digits, entry_cnt, k, ev);
                end else if (k == kclc_pkg::KEY_B) begin
                    if (entry_cnt == PIN_LEN && fresh_cnt == PIN_LEN &&
                        entry_digits == fresh_digits) begin
                        saved_code = entry_digits;
                        ev         = kclc_pkg::EV_CHANGED;
                    end else begin
                        ev = kclc_pkg::EV_MISMATCH;
                    end
                    entry_digits = '0;
                    entry_cnt    = '0;
                    fresh_digits = '0;
                    fresh_cnt    = '0;
                    lock_mode    = kclc_pkg::MODE_OPEN;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic kclc_pkg::t_result lock_step(input kclc_pkg::t_item it);
        kclc_pkg::t_event  ev;
        logic              beep;
        kclc_pkg::t_result r;
        ev   = kclc_pkg::EV_NONE;
        beep = 1'b0;
        if (it.cmd == 1'b0) begin
            take_sample(it.now_ms, it.distance_mm, ev);
        end else begin
            beep = (it.key_code <= kclc_pkg::KEY_D);
            press_key(it.key_code, ev);
        end
        r.door_is_open = door_unlocked;
        r.mode_now     = lock_mode;
        r.event_code   = ev;
        r.key_beep     = beep;
        r.digits_shown = (lock_mode == kclc_pkg::MODE_NEW) ? fresh_cnt : entry_cnt;
        return r;
    endfunction

    // predict at planning time; the result is queued for checking once the item is taken
    function automatic void add_item(input logic cmd, input logic [31:0] now,
                                     input logic [15:0] mm, input logic [3:0] k);
        t_planned p;
        p.item.cmd         = cmd;
        p.item.now_ms      = now;
        p.item.distance_mm = mm;
        p.item.key_code    = k;
        p.want             = lock_step(p.item);
        queued_items.push_back(p);
        planned_total++;
    endfunction

    function automatic void add_key(input logic [3:0] k);
        add_item(1'b1, $urandom, 16'($urandom), k);
    endfunction

    function automatic void add_sample(input logic [31:0] step, input logic [15:0] mm);
        now_t = now_t + step;
        add_item(1'b0, now_t, mm, 4'($urandom));
    endfunction

    function automatic logic [15:0] near_mm();
        return 16'($urandom_range(cfg_threshold, 0));
    endfunction

    function automatic logic [15:0] far_mm();
        if ($urandom_range(3) == 0) return kclc_pkg::NO_ECHO;
        return 16'($urandom_range(65535, int'(cfg_threshold) + 1));
    endfunction

    function automatic logic [31:0] pick_step();
        case ($urandom_range(3))
            0:       return $urandom_range(cfg_interval, 0);
            1:       return {16'h0, cfg_interval};
            2:       return $urandom;
            default: return cfg_interval + $urandom_range(1000);
        endcase
    endfunction

    function automatic void enter_code(input bit right);
        int r;
        int n;
        if (lock_mode == kclc_pkg::MODE_IDLE)
            add_sample(cfg_interval + $urandom_range(40), near_mm());
        if (lock_mode != kclc_pkg::MODE_AWAIT) return;
        r = $urandom_range(9);
        if (right || r < 6) begin
            for (int i = 0; i < PIN_LEN; i++) add_key(saved_code[4 * (3 - i) +: 4]);
        end else begin
            n = $urandom_range(5);
            repeat (n) add_key(4'($urandom_range(9)));
        end
        if (r == 9) add_key(4'($urandom_range(9)));
        if (!right && $urandom_range(7) == 0) add_key(kclc_pkg::KEY_C);
        else add_key(kclc_pkg::KEY_D);
    endfunction

    function automatic void change_code();
        logic [3:0] d[PIN_LEN];
        int         n;
        int         r;
        if (lock_mode != kclc_pkg::MODE_OPEN) enter_code(1'b1);
        if (lock_mode != kclc_pkg::MODE_OPEN) return;
        add_key(kclc_pkg::KEY_A);
        foreach (d[i]) d[i] = 4'($urandom_range(9));
        n = ($urandom_range(7) == 0) ? $urandom_range(3) : PIN_LEN;
        for (int i = 0; i < n; i++) add_key(d[i]);
        // premature B is ignored, finish the digits afterwards
        if (n < PIN_LEN) begin
            add_key(kclc_pkg::KEY_B);
            for (int i = n; i < PIN_LEN; i++) add_key(d[i]);
        end
        add_key(kclc_pkg::KEY_B);
        r = $urandom_range(7);
        if (r == 0) d[$urandom_range(3)] = 4'($urandom_range(9));
        n = (r == 1) ? $urandom_range(3) : PIN_LEN;
        for (int i = 0; i < n; i++) add_key(d[i]);
        add_key(kclc_pkg::KEY_B);
    endfunction

    function automatic void walk_away();
        int n;
        add_sample(cfg_timeout + 1 + $urandom_range(50), far_mm());
        n = $urandom_range(3);
        repeat (n) begin
            if ($urandom_range(1)) add_sample(cfg_autoclose, far_mm());
            else add_sample(cfg_autoclose / 2 + cfg_interval, far_mm());
        end
    endfunction

    task automatic wait_until_quiet();
        while (queued_items.size() > 0 || in_ch.valid || awaited_results.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_register(input kclc_pkg::t_reg_index idx, input logic [31:0] value);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            kclc_pkg::REG_THRESHOLD: cfg_threshold = value[15:0];
            kclc_pkg::REG_TIMEOUT:   cfg_timeout   = value;
            kclc_pkg::REG_AUTOCLOSE: cfg_autoclose = value;
            default:                 cfg_interval  = value[15:0];
        endcase
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n            = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = kclc_pkg::REG_THRESHOLD;
        cfg_ch.data        = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed walk through the modes at reset settings
        add_key(4'd5);
        add_key(4'd15);
        add_sample(32'd50, 16'd0);           // too soon after reset
        add_sample(32'd150, 16'd500);        // exactly at threshold
        add_key(kclc_pkg::KEY_D);
        add_key(4'd1);
        add_key(4'd2);
        add_key(4'd3);
        add_key(4'd4);
        add_key(4'd0);                       // buffer already full
        add_key(kclc_pkg::KEY_D);
        add_key(kclc_pkg::KEY_A);
        add_key(4'd9);
        add_key(kclc_pkg::KEY_B);            // new code still short
        add_key(4'd8);
        add_key(4'd7);
        add_key(4'd6);
        add_key(kclc_pkg::KEY_B);
        add_key(4'd14);
        add_key(kclc_pkg::KEY_B);
        add_key(kclc_pkg::KEY_C);
        add_sample(32'd10001, kclc_pkg::NO_ECHO);
        wait_until_quiet();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                1: begin
                    set_register(kclc_pkg::REG_THRESHOLD, 32'd65534);
                    set_register(kclc_pkg::REG_TIMEOUT, 32'd0);
                    set_register(kclc_pkg::REG_AUTOCLOSE, 32'd0);
                    set_register(kclc_pkg::REG_INTERVAL, 32'd0);
                end
                2: begin
                    set_register(kclc_pkg::REG_THRESHOLD, 32'd0);
                    set_register(kclc_pkg::REG_TIMEOUT, 32'hFFFF_FFFF);
                    set_register(kclc_pkg::REG_AUTOCLOSE, 32'hFFFF_FFFF);
                    set_register(kclc_pkg::REG_INTERVAL, 32'd65535);
                end
                3: begin
                    set_register(kclc_pkg::REG_THRESHOLD, 32'd500);
                    set_register(kclc_pkg::REG_TIMEOUT, 32'd2000);
                    set_register(kclc_pkg::REG_AUTOCLOSE, 32'd5000);
                    set_register(kclc_pkg::REG_INTERVAL, 32'd100);
                end
                4: begin
                    set_register(kclc_pkg::REG_THRESHOLD, $urandom_range(65534));
                    set_register(kclc_pkg::REG_TIMEOUT, $urandom_range(20000));
                    set_register(kclc_pkg::REG_AUTOCLOSE, $urandom_range(20000));
                    set_register(kclc_pkg::REG_INTERVAL, $urandom_range(300));
                end
                5: begin
                    set_register(kclc_pkg::REG_THRESHOLD, $urandom_range(65534));
                    set_register(kclc_pkg::REG_TIMEOUT, $urandom);
                    set_register(kclc_pkg::REG_AUTOCLOSE, $urandom);
                    set_register(kclc_pkg::REG_INTERVAL, $urandom_range(65535));
                end
                default: ;
            endcase
            begin
                int target;
                int r;
                target = planned_total + PHASE_ITEMS;
                while (planned_total < target) begin
                    r = $urandom_range(99);
                    if (r < 30) enter_code(r < 20);
                    else if (r < 50) change_code();
                    else if (r < 65) walk_away();
                    else if (r < 80)
                        add_sample(pick_step(), $urandom_range(1) ? near_mm() : far_mm());
                    else if (r < 90) add_key(4'($urandom_range(15)));
                    else add_sample(pick_step(), 16'($urandom));
                end
            end
            wait_until_quiet();
        end

        if (error_count == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

    // sender: bursts of items separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid       <= 1'b0;
            in_ch.cmd         <= 1'b0;
            in_ch.now_ms      <= '0;
            in_ch.distance_mm <= '0;
            in_ch.key_code    <= '0;
        end else begin
            if (in_ch.valid && in_ch.ready) awaited_results.push_back(driven_want);
            if (!in_ch.valid || in_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_ch.valid <= 1'b0;
                end else if (queued_items.size() > 0) begin
                    t_planned p;
                    p = queued_items.pop_front();
                    driven_want       = p.want;
                    in_ch.valid       <= 1'b1;
                    in_ch.cmd         <= p.item.cmd;
                    in_ch.now_ms      <= p.item.now_ms;
                    in_ch.distance_mm <= p.item.distance_mm;
                    in_ch.key_code    <= p.item.key_code;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(20, 1);
                        gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern cycles through four modes over time; check each result
    always @(posedge i_clk) begin
        kclc_pkg::t_result want;
        logic              bad;
        cycles++;
        case ((cycles / 300) % 4)
            0:       out_ch.ready <= 1'b1;
            1:       out_ch.ready <= 1'($urandom_range(1));
            2:       out_ch.ready <= ($urandom_range(3) == 0);
            default: out_ch.ready <= (cycles % 5) != 0;
        endcase
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("result %0d with nothing pending: door %0d mode %0d event %0d",
                             results_seen, out_ch.door_is_open, out_ch.mode_now,
                             out_ch.event_code);
            end else begin
                want = awaited_results.pop_front();
                bad = (out_ch.door_is_open !== want.door_is_open) ||
                      (out_ch.mode_now     !== want.mode_now)     ||
                      (out_ch.event_code   !== want.event_code)   ||
                      (out_ch.key_beep     !== want.key_beep)     ||
                      (out_ch.digits_shown !== want.digits_shown);
                if (bad) begin
                    error_count++;
                    if (error_count <= 10)
                        $display({"result %0d: expected door %0d mode %0d event %0d beep %0d ",
                                  "shown %0d, got door %0d mode %0d event %0d beep %0d shown %0d"},
                                 results_seen, want.door_is_open, want.mode_now,
                                 want.event_code, want.key_beep, want.digits_shown,
                                 out_ch.door_is_open, out_ch.mode_now, out_ch.event_code,
                                 out_ch.key_beep, out_ch.digits_shown);
                end
            end
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule
